### src/dnsloc_pkg.sv
// Shared types, constants and decode functions for the DNS LOC record decoder.
// No dependencies; used by dnsloc_decode and dns_loc_record_decoder.
package dnsloc_pkg;

  localparam int unsigned RecLen   = 16;
  localparam int unsigned CntW     = 5;
  localparam int unsigned CmW      = 54;
  localparam int unsigned PowW     = 50;
  localparam logic [CntW-1:0] CountMax = 5'd31;
  localparam logic [CntW-1:0] LastIdx  = 5'd15;
  localparam logic [31:0] LatLonBias = 32'h8000_0000;
  localparam logic [31:0] AltBias    = 32'd10000000;

  localparam logic [PowW-1:0] Pow10Table [16] = '{
    50'd1, 50'd10, 50'd100, 50'd1000, 50'd10000, 50'd100000, 50'd1000000,
    50'd10000000, 50'd100000000, 50'd1000000000, 50'd10000000000,
    50'd100000000000, 50'd1000000000000, 50'd10000000000000,
    50'd100000000000000, 50'd1000000000000000
  };

  typedef logic [RecLen-1:0][7:0] rec_t;

  typedef struct packed {
    logic               status;
    logic [7:0]         version;
    logic [CmW-1:0]     size_cm;
    logic [CmW-1:0]     horiz_prec_cm;
    logic [CmW-1:0]     vert_prec_cm;
    logic signed [31:0] lat_offset;
    logic signed [31:0] lon_offset;
    logic signed [31:0] alt_offset;
    logic [63:0]        morton_code;
  } result_t;

  function automatic logic [CmW-1:0] decode_cm(input logic [7:0] code);
    logic [CmW-1:0] mant;
    logic [CmW-1:0] pw;
    mant = {{(CmW-4){1'b0}}, code[7:4]};
    pw   = {{(CmW-PowW){1'b0}}, Pow10Table[code[3:0]]};
    return mant * pw;
  endfunction

  function automatic logic [31:0] word_at(input rec_t rec, input int unsigned base);
    return {rec[base], rec[base+1], rec[base+2], rec[base+3]};
  endfunction

endpackage

### src/dnsloc_decode.sv
// Decodes one stored 16-byte LOC record into a result beat.
// Depends on dnsloc_pkg.
module dnsloc_decode (
  input  dnsloc_pkg::rec_t    rec_i,
  input  logic                len_ok_i,
  output dnsloc_pkg::result_t res_o
);
  import dnsloc_pkg::*;

  logic [31:0] lat;
  logic [31:0] lon;
  logic [31:0] alt;
  logic [63:0] morton;

  assign lat = word_at(rec_i, 4) - LatLonBias;
  assign lon = word_at(rec_i, 8) - LatLonBias;
  assign alt = word_at(rec_i, 12) - AltBias;

  always_comb begin
    for (int i = 0; i < 32; i++) begin
      morton[2*i]   = lat[i];
      morton[2*i+1] = lon[i];
    end
  end

  always_comb begin
    res_o = '0;
    if (len_ok_i) begin
      res_o.version       = rec_i[0];
      res_o.size_cm       = decode_cm(rec_i[1]);
      res_o.horiz_prec_cm = decode_cm(rec_i[2]);
      res_o.vert_prec_cm  = decode_cm(rec_i[3]);
      res_o.lat_offset    = lat;
      res_o.lon_offset    = lon;
      res_o.alt_offset    = alt;
      res_o.morton_code   = morton;
    end else begin
      res_o.status = 1'b1;
    end
  end

endmodule

### src/dns_loc_record_decoder.sv
// DNS LOC record decoder top level: byte collection, decode stage, output register.
// Takes one byte beat per cycle unless stalled; results pass the output register.
// The record store has no reset; only the byte count and the valid flags are cleared.
// Throughput is one byte per cycle while the output side keeps taking results.
// Depends on dnsloc_pkg and dnsloc_decode.
module dns_loc_record_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rdata_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        status_o,
  output logic [7:0]  version_o,
  output logic [53:0] size_cm_o,
  output logic [53:0] horiz_prec_cm_o,
  output logic [53:0] vert_prec_cm_o,
  output logic signed [31:0] lat_offset_o,
  output logic signed [31:0] lon_offset_o,
  output logic signed [31:0] alt_offset_o,
  output logic [63:0] morton_code_o
);
  import dnsloc_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  rec_t            rec_q;
  logic            pend_q, pend_d;
  logic            len_ok_q;
  logic            out_valid_q, out_valid_d;
  result_t         res_q;
  result_t         dec_res;
  logic            in_acc;
  logic            move;

  assign move       = pend_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !pend_q || move;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      if (last_byte_i) begin
        cnt_d = '0;
      end else if (cnt_q != CountMax) begin
        cnt_d = cnt_q + 5'd1;
      end
    end
  end

  assign pend_d      = (in_acc && last_byte_i) || (pend_q && !move);
  assign out_valid_d = move || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !cnt_q[CntW-1]) begin
      rec_q[cnt_q[CntW-2:0]] <= rdata_byte_i;
    end
    if (in_acc && last_byte_i) begin
      len_ok_q <= (cnt_q == LastIdx);
    end
    if (move) begin
      res_q <= dec_res;
    end
  end

  dnsloc_decode u_decode (
    .rec_i    (rec_q),
    .len_ok_i (len_ok_q),
    .res_o    (dec_res)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign version_o       = res_q.version;
  assign size_cm_o       = res_q.size_cm;
  assign horiz_prec_cm_o = res_q.horiz_prec_cm;
  assign vert_prec_cm_o  = res_q.vert_prec_cm;
  assign lat_offset_o    = res_q.lat_offset;
  assign lon_offset_o    = res_q.lon_offset;
  assign alt_offset_o    = res_q.alt_offset;
  assign morton_code_o   = res_q.morton_code;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (pend_q && out_valid_o && !out_ready_i))
    else $error("Input stalled without a blocked result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_byte_i) |=> (pend_q && cnt_q == '0))
    else $error("Last byte did not start a decode.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !last_byte_i && cnt_q != CountMax) |=> (cnt_q == $past(cnt_q) + 5'd1))
    else $error("Byte count did not advance.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (size_cm_o == '0 && morton_code_o == '0
                                   && version_o == '0))
    else $error("Rejected record carries nonzero fields.");

endmodule

### tb/dnsloc_result_checker.sv
// Result checker for the DNS LOC record decoder: watches both channels, predicts
// each decoded record and compares every result beat field by field.
// Depends on dnsloc_pkg for the result layout and the bias constants.
`timescale 1ns / 100ps

module dnsloc_result_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        rdata_byte_i,
  input  logic              last_byte_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              status_i,
  input  logic [7:0]        version_i,
  input  logic [dnsloc_pkg::CmW-1:0] size_cm_i,
  input  logic [dnsloc_pkg::CmW-1:0] horiz_prec_cm_i,
  input  logic [dnsloc_pkg::CmW-1:0] vert_prec_cm_i,
  input  logic signed [31:0] lat_offset_i,
  input  logic signed [31:0] lon_offset_i,
  input  logic signed [31:0] alt_offset_i,
  input  logic [63:0]       morton_code_i,
  output int                errors_o,
  output int                pending_o
);
  import dnsloc_pkg::*;

  result_t         decoded_q[$];
  logic [CntW-1:0] byte_cnt;
  logic [7:0]      rec_store [RecLen];
  int              mismatches = 0;

  function automatic logic [CmW-1:0] decode_size_code(input logic [7:0] code);
    logic [63:0] value;
    value = {60'd0, code[7:4]};
    for (int i = 0; i < int'(code[3:0]); i++) begin
      value = value * 64'd10;
    end
    return value[CmW-1:0];
  endfunction

  function automatic logic [63:0] interleave_latlon(input logic [31:0] lat,
                                                     input logic [31:0] lon);
    logic [63:0] code;
    code = '0;
    for (int i = 0; i < 32; i++) begin
      code[2*i]   = lat[i];
      code[2*i+1] = lon[i];
    end
    return code;
  endfunction

  task automatic check_field(input string field, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatches < 10) begin
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, field, exp_v, act_v);
      end
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t     exp_r;
    logic [31:0] lat;
    logic [31:0] lon;
    logic [31:0] alt;
    if (!rst_ni) begin
      byte_cnt = '0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          check_field("result beat with nothing pending", 64'd0, 64'd1);
        end else begin
          exp_r = decoded_q.pop_front();
          check_field("status", {63'd0, exp_r.status}, {63'd0, status_i});
          check_field("version", {56'd0, exp_r.version}, {56'd0, version_i});
          check_field("size_cm", {10'd0, exp_r.size_cm}, {10'd0, size_cm_i});
          check_field("horiz_prec_cm", {10'd0, exp_r.horiz_prec_cm},
                      {10'd0, horiz_prec_cm_i});
          check_field("vert_prec_cm", {10'd0, exp_r.vert_prec_cm},
                      {10'd0, vert_prec_cm_i});
          check_field("lat_offset", {32'd0, exp_r.lat_offset}, {32'd0, lat_offset_i});
          check_field("lon_offset", {32'd0, exp_r.lon_offset}, {32'd0, lon_offset_i});
          check_field("alt_offset", {32'd0, exp_r.alt_offset}, {32'd0, alt_offset_i});
          check_field("morton_code", exp_r.morton_code, morton_code_i);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (byte_cnt < RecLen) begin
          rec_store[byte_cnt[3:0]] = rdata_byte_i;
        end
        if (byte_cnt != CountMax) begin
          byte_cnt = byte_cnt + 1'b1;
        end
        if (last_byte_i) begin
          exp_r = '0;
          if (byte_cnt != CntW'(RecLen)) begin
            exp_r.status = 1'b1;
          end else begin
            lat = {rec_store[4], rec_store[5], rec_store[6], rec_store[7]} - LatLonBias;
            lon = {rec_store[8], rec_store[9], rec_store[10], rec_store[11]} - LatLonBias;
            alt = {rec_store[12], rec_store[13], rec_store[14], rec_store[15]} - AltBias;
            exp_r.version       = rec_store[0];
            exp_r.size_cm       = decode_size_code(rec_store[1]);
            exp_r.horiz_prec_cm = decode_size_code(rec_store[2]);
            exp_r.vert_prec_cm  = decode_size_code(rec_store[3]);
            exp_r.lat_offset    = lat;
            exp_r.lon_offset    = lon;
            exp_r.alt_offset    = alt;
            exp_r.morton_code   = interleave_latlon(lat, lon);
          end
          decoded_q.push_back(exp_r);
          byte_cnt = '0;
        end
      end
    end
    errors_o  = mismatches;
    pending_o = decoded_q.size();
  end

endmodule

### tb/tb_dns_loc_record_decoder.sv
// Testbench top for the DNS LOC record decoder: drives byte beats and result
// stalls, and gives the verdict from the failure count of dnsloc_result_checker.
// Depends on dnsloc_pkg, dns_loc_record_decoder and dnsloc_result_checker.
`timescale 1ns / 100ps

module tb_dns_loc_record_decoder;
  import dnsloc_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBytes = 410;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [7:0]        rdata_byte_i  = 8'd0;
  logic              last_byte_i   = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic              status_o;
  logic [7:0]        version_o;
  logic [CmW-1:0]    size_cm_o;
  logic [CmW-1:0]    horiz_prec_cm_o;
  logic [CmW-1:0]    vert_prec_cm_o;
  logic signed [31:0] lat_offset_o;
  logic signed [31:0] lon_offset_o;
  logic signed [31:0] alt_offset_o;
  logic [63:0]       morton_code_o;
  int                errors;
  int                pending;

  int unsigned       cycles      = 0;
  int unsigned       burst_left  = 0;
  int unsigned       bytes_sent  = 0;
  int unsigned       hold_left   = 0;
  bit                hold_done   = 1'b0;
  logic [7:0]        record_q[$];

  dns_loc_record_decoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rdata_byte_i   (rdata_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .version_o      (version_o),
    .size_cm_o      (size_cm_o),
    .horiz_prec_cm_o(horiz_prec_cm_o),
    .vert_prec_cm_o (vert_prec_cm_o),
    .lat_offset_o   (lat_offset_o),
    .lon_offset_o   (lon_offset_o),
    .alt_offset_o   (alt_offset_o),
    .morton_code_o  (morton_code_o)
  );

  dnsloc_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .rdata_byte_i   (rdata_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .version_i      (version_o),
    .size_cm_i      (size_cm_o),
    .horiz_prec_cm_i(horiz_prec_cm_o),
    .vert_prec_cm_i (vert_prec_cm_o),
    .lat_offset_i   (lat_offset_o),
    .lon_offset_i   (lon_offset_o),
    .alt_offset_i   (alt_offset_o),
    .morton_code_i  (morton_code_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver cycles through always-ready, random and sparse stall patterns.
  // Once, it holds off for a long stretch so the decoder backs up into its input.
  always @(negedge clk_i) begin
    if (!hold_done && rst_ni && cycles >= 400) begin
      hold_done = 1'b1;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_ready_i = 1'b0;
    end else begin
      case ((cycles / 80) % 3)
        0:       out_ready_i = 1'b1;
        1:       out_ready_i = 1'($urandom_range(0, 1));
        default: out_ready_i = (cycles % 4 == 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid_i   = 1'b1;
    rdata_byte_i = data;
    last_byte_i  = is_last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    burst_left = burst_left - 1;
    bytes_sent = bytes_sent + 1;
  endtask

  task automatic send_record();
    while (record_q.size() > 0) begin
      send_byte(record_q[0], record_q.size() == 1);
      void'(record_q.pop_front());
    end
  endtask

  task automatic push_word(input logic [31:0] word);
    for (int i = 3; i >= 0; i--) begin
      record_q.push_back(word[8*i +: 8]);
    end
  endtask

  task automatic send_loc(input logic [7:0] ver, input logic [7:0] size_code,
                          input logic [7:0] hp_code, input logic [7:0] vp_code,
                          input logic [31:0] lat, input logic [31:0] lon,
                          input logic [31:0] alt);
    record_q.push_back(ver);
    record_q.push_back(size_code);
    record_q.push_back(hp_code);
    record_q.push_back(vp_code);
    push_word(lat);
    push_word(lon);
    push_word(alt);
    send_record();
  endtask

  task automatic send_filler(input int unsigned len);
    repeat (len) record_q.push_back(8'($urandom_range(0, 255)));
    send_record();
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Zero mantissas with large exponents, the largest code, and the extremes of
    // the coordinate words, including an altitude below the bias.
    send_loc(8'h00, 8'h00, 8'hF0, 8'h0F, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_loc(8'hFF, 8'hFF, 8'h9A, 8'h1B, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_loc(8'h5A, 8'hA5, 8'h3C, 8'hE7, 32'h7FFF_FFFF, 32'h0098_9680, 32'h0098_9680);
    // Wrong lengths: one byte, one short, one over, and a long one past saturation.
    send_filler(1);
    send_filler(15);
    send_filler(17);
    send_filler(40);
    send_loc(8'h00, 8'h12, 8'h16, 8'h13, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0098_967F);

    bytes_sent = 0;
    while (bytes_sent < RandomBytes) begin
      if ($urandom_range(0, 3) != 0) begin
        send_filler(16);
      end else begin
        send_filler($urandom_range(1, 40));
      end
    end
    in_valid_i  = 1'b0;
    last_byte_i = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
